// ----- hdl/top_k_score_selector_unit_assert.svh -----
// assertion helpers for the top-k score selector
// both sample on i_clk and are off while i_rst_n is low
`ifndef TOP_K_SCORE_SELECTOR_UNIT_ASSERT_SVH
`define TOP_K_SCORE_SELECTOR_UNIT_ASSERT_SVH

// property holds at every active edge
`define TKSEL_HOLD(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("top_k_score_selector_unit: invariant violated");

// condition at one edge implies a property at the next edge
`define TKSEL_IMPLY_NEXT(label, cond, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error("top_k_score_selector_unit: next-cycle check failed");

`endif

// ----- hdl/tksel_pkg.sv -----
`timescale 1ns / 1ps

package tksel_pkg;

    localparam int CMD_W   = 2;
    localparam int ITEM_W  = 20;
    localparam int SCORE_W = 32;
    localparam int RANK_W  = 6;
    localparam int MATCH_W = 7;
    localparam int HIT_W   = 16;

    localparam int LIST_DEPTH_DEF = 50;
    localparam int ITEM_BITS_DEF  = 20;

    // slots per popcount group, and the width of one group count
    localparam int GRP_W  = 8;
    localparam int GSUM_W = $clog2(GRP_W + 1);

    localparam logic signed [SCORE_W-1:0] SCORE_FLOOR = {1'b1, {(SCORE_W-1){1'b0}}};
    localparam logic [HIT_W-1:0]          HIT_MAX     = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR = 2'd0,
        CMD_OFFER = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    // broadcast from the front end to every slot cell
    typedef struct packed {
        logic                      en;
        logic                      clr;
        logic                      ins;
        logic                      qry;
        logic signed [SCORE_W-1:0] score;
    } t_bcast;

endpackage

// ----- hdl/tksel_cell.sv -----
`timescale 1ns / 1ps

module tksel_cell #(
    parameter int ITEM_BITS = tksel_pkg::ITEM_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  tksel_pkg::t_bcast                    i_bc,
    input  logic [ITEM_BITS-1:0]                 i_new_item,
    input  logic                                 i_up_le,
    input  logic [ITEM_BITS-1:0]                 i_up_item,
    input  logic signed [tksel_pkg::SCORE_W-1:0] i_up_score,
    output logic                                 o_le,
    output logic [ITEM_BITS-1:0]                 o_item,
    output logic signed [tksel_pkg::SCORE_W-1:0] o_score,
    output logic                                 o_match
);

    logic [ITEM_BITS-1:0]                 r_item;
    logic signed [tksel_pkg::SCORE_W-1:0] r_score;
    logic                                 r_match;

    // slot score not above the offered score
    assign o_le    = (r_score <= i_bc.score);
    assign o_item  = r_item;
    assign o_score = r_score;
    assign o_match = r_match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item  <= '0;
            r_score <= tksel_pkg::SCORE_FLOOR;
            r_match <= 1'b0;
        end else if (i_bc.en) begin
            r_match <= i_bc.qry && (r_item == i_new_item);
            if (i_bc.clr) begin
                r_item  <= '0;
                r_score <= tksel_pkg::SCORE_FLOOR;
            end else if (i_bc.ins && o_le) begin
                // upper neighbor also qualifies: shift down, else this is the slot
                if (i_up_le) begin
                    r_item  <= i_up_item;
                    r_score <= i_up_score;
                end else begin
                    r_item  <= i_new_item;
                    r_score <= i_bc.score;
                end
            end
        end
    end

endmodule

// ----- hdl/tksel_cnt.sv -----
`timescale 1ns / 1ps

module tksel_cnt #(
    parameter  int N_IN = tksel_pkg::LIST_DEPTH_DEF,
    localparam int NGRP = (N_IN + tksel_pkg::GRP_W - 1) / tksel_pkg::GRP_W
) (
    input  logic                                     i_clk,
    input  logic                                     i_en,
    input  logic [N_IN-1:0]                          i_bits,
    output logic [NGRP-1:0][tksel_pkg::GSUM_W-1:0]   o_grp_sum
);

    localparam int PAD_W  = NGRP * tksel_pkg::GRP_W;
    localparam int GRP_W  = tksel_pkg::GRP_W;
    localparam int GSUM_W = tksel_pkg::GSUM_W;

    logic [PAD_W-1:0]                 w_pad;
    logic [NGRP-1:0][GSUM_W-1:0]      w_sum;
    logic [NGRP-1:0][GSUM_W-1:0]      r_grp_sum;

    assign w_pad = PAD_W'(i_bits);

    // popcount per group of slots
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            w_sum[g] = '0;
            for (int b = 0; b < GRP_W; b++) begin
                w_sum[g] = w_sum[g] + GSUM_W'(w_pad[g*GRP_W + b]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_grp_sum <= w_sum;
        end
    end

    assign o_grp_sum = r_grp_sum;

endmodule

// ----- hdl/top_k_score_selector_unit.sv -----
// top-k score selector: sorted list of the best-scored items held in a row of slot cells
// throughput: one command per cycle, the whole pipe stalls only when the result is not taken
// pipeline from input transfer to result valid: cells, group count, total
// an offer is a parallel compare and shift-down across the cell chain
// reset (sync, active low): all slots item 0 at the most negative score, hit count 0, pipe empty
`timescale 1ns / 1ps

`include "top_k_score_selector_unit_assert.svh"

module top_k_score_selector_unit #(
    parameter int LIST_DEPTH = tksel_pkg::LIST_DEPTH_DEF,
    parameter int ITEM_BITS  = tksel_pkg::ITEM_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // command channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [tksel_pkg::CMD_W-1:0]          i_command,
    input  logic [tksel_pkg::ITEM_W-1:0]         i_item_index,
    input  logic signed [tksel_pkg::SCORE_W-1:0] i_score,
    input  logic                                 i_already_trained,
    input  logic [tksel_pkg::RANK_W-1:0]         i_rank,
    // result channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [tksel_pkg::MATCH_W-1:0]        o_slot_matches,
    output logic [tksel_pkg::HIT_W-1:0]          o_hit_total,
    output logic [tksel_pkg::ITEM_W-1:0]         o_read_item,
    output logic signed [tksel_pkg::SCORE_W-1:0] o_read_score
);

    localparam int ITEM_W  = tksel_pkg::ITEM_W;
    localparam int SCORE_W = tksel_pkg::SCORE_W;
    localparam int MATCH_W = tksel_pkg::MATCH_W;
    localparam int HIT_W   = tksel_pkg::HIT_W;
    localparam int RANK_W  = tksel_pkg::RANK_W;
    localparam int GSUM_W  = tksel_pkg::GSUM_W;
    localparam int IDX_W   = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int NGRP    = (LIST_DEPTH + tksel_pkg::GRP_W - 1) / tksel_pkg::GRP_W;

    // ---------------------------------------------------------------
    // handshake: every stage moves together when the result register frees up
    // ---------------------------------------------------------------
    logic              w_adv;
    logic              w_acc;
    tksel_pkg::t_cmd   w_cmd;
    tksel_pkg::t_bcast w_bc;
    logic [ITEM_BITS-1:0] w_new_item;

    assign w_adv      = !o_out_valid || i_out_ready;
    assign o_in_ready = w_adv;
    assign w_acc      = i_in_valid && w_adv;
    assign w_cmd      = tksel_pkg::t_cmd'(i_command);
    // items are kept at ITEM_BITS bits
    assign w_new_item = ITEM_BITS'(i_item_index);

    // command broadcast to all cells; trained candidates never insert
    always_comb begin
        w_bc.en    = w_acc;
        w_bc.clr   = (w_cmd == tksel_pkg::CMD_CLEAR);
        w_bc.ins   = (w_cmd == tksel_pkg::CMD_OFFER) && !i_already_trained;
        w_bc.qry   = (w_cmd == tksel_pkg::CMD_QUERY);
        w_bc.score = i_score;
    end

    // ---------------------------------------------------------------
    // slot cell chain, slot 0 lowest; each cell reads its upper neighbor
    // ---------------------------------------------------------------
    logic [LIST_DEPTH-1:0]               w_le;
    logic [LIST_DEPTH-1:0]               w_match;
    logic [ITEM_BITS-1:0]                w_items  [LIST_DEPTH];
    logic signed [SCORE_W-1:0]           w_scores [LIST_DEPTH];

    for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_slot
        logic                      w_up_le;
        logic [ITEM_BITS-1:0]      w_up_item;
        logic signed [SCORE_W-1:0] w_up_score;

        if (g == LIST_DEPTH - 1) begin : g_top
            // top slot has no neighbor above: it takes the new item when it qualifies
            assign w_up_le    = 1'b0;
            assign w_up_item  = '0;
            assign w_up_score = tksel_pkg::SCORE_FLOOR;
        end else begin : g_mid
            assign w_up_le    = w_le[g+1];
            assign w_up_item  = w_items[g+1];
            assign w_up_score = w_scores[g+1];
        end

        tksel_cell #(
            .ITEM_BITS (ITEM_BITS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_bc       (w_bc),
            .i_new_item (w_new_item),
            .i_up_le    (w_up_le),
            .i_up_item  (w_up_item),
            .i_up_score (w_up_score),
            .o_le       (w_le[g]),
            .o_item     (w_items[g]),
            .o_score    (w_scores[g]),
            .o_match    (w_match[g])
        );
    end

    // ---------------------------------------------------------------
    // stage 1: match bits sit in the cells, read slot captured here
    // ---------------------------------------------------------------
    logic                      w_rd_ok;
    logic [IDX_W-1:0]          w_rd_idx;
    logic                      r_v1;
    tksel_pkg::t_cmd           r1_cmd;
    logic [ITEM_BITS-1:0]      r1_item;
    logic signed [SCORE_W-1:0] r1_score;

    assign w_rd_ok  = ({1'b0, i_rank} < (RANK_W + 1)'(LIST_DEPTH));
    assign w_rd_idx = i_rank[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_cmd <= w_cmd;
            if ((w_cmd == tksel_pkg::CMD_READ) && w_rd_ok) begin
                r1_item  <= w_items[w_rd_idx];
                r1_score <= w_scores[w_rd_idx];
            end else begin
                r1_item  <= '0;
                r1_score <= '0;
            end
        end
    end

    // ---------------------------------------------------------------
    // stage 2: per-group match counts
    // ---------------------------------------------------------------
    logic [NGRP-1:0][GSUM_W-1:0] w_grp_sum;
    logic                        r_v2;
    tksel_pkg::t_cmd             r2_cmd;
    logic [ITEM_BITS-1:0]        r2_item;
    logic signed [SCORE_W-1:0]   r2_score;

    tksel_cnt #(
        .N_IN (LIST_DEPTH)
    ) u_cnt (
        .i_clk     (i_clk),
        .i_en      (w_adv),
        .i_bits    (w_match),
        .o_grp_sum (w_grp_sum)
    );

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_cmd   <= r1_cmd;
            r2_item  <= r1_item;
            r2_score <= r1_score;
        end
    end

    // ---------------------------------------------------------------
    // stage 3: total matches, saturating hit count, result register
    // ---------------------------------------------------------------
    logic [MATCH_W-1:0]        w_sum;
    logic [HIT_W:0]            w_hit_add;
    logic [HIT_W-1:0]          w_hit_sat;
    logic [HIT_W-1:0]          r_hits;
    logic                      r_v3;
    logic [MATCH_W-1:0]        r3_matches;
    logic [ITEM_BITS-1:0]      r3_item;
    logic signed [SCORE_W-1:0] r3_score;

    always_comb begin
        w_sum = '0;
        for (int g = 0; g < NGRP; g++) begin
            w_sum = w_sum + MATCH_W'(w_grp_sum[g]);
        end
    end

    assign w_hit_add = {1'b0, r_hits} + (HIT_W + 1)'(w_sum);
    assign w_hit_sat = w_hit_add[HIT_W] ? tksel_pkg::HIT_MAX : w_hit_add[HIT_W-1:0];

    // valid bits and hit count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_hits <= '0;
        end else if (w_adv) begin
            r_v1 <= w_acc;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (r_v2) begin
                case (r2_cmd)
                    tksel_pkg::CMD_CLEAR: r_hits <= '0;
                    tksel_pkg::CMD_QUERY: r_hits <= w_hit_sat;
                    default:              r_hits <= r_hits;
                endcase
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_matches <= (r2_cmd == tksel_pkg::CMD_QUERY) ? w_sum : '0;
            r3_item    <= r2_item;
            r3_score   <= r2_score;
        end
    end

    assign o_out_valid    = r_v3;
    assign o_slot_matches = r3_matches;
    assign o_hit_total    = r_hits;
    assign o_read_item    = ITEM_W'(r3_item);
    assign o_read_score   = r3_score;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    // lowest slot score never exceeds the top slot score
    `TKSEL_HOLD(a_list_sorted, w_scores[0] <= w_scores[LIST_DEPTH-1])
    // hit count only moves when a clear or query reaches the last stage
    `TKSEL_IMPLY_NEXT(a_hits_stable, !(w_adv && r_v2 && (r2_cmd == tksel_pkg::CMD_CLEAR || r2_cmd == tksel_pkg::CMD_QUERY)), $stable(r_hits))
    // match count never exceeds the number of slots
    `TKSEL_HOLD(a_match_range, o_slot_matches <= MATCH_W'(LIST_DEPTH))
    // empty result register never blocks new transfers
    `TKSEL_HOLD(a_ready_when_empty, !o_out_valid |-> o_in_ready)

endmodule

// ----- tb/sv/top_k_score_selector_unit_tb.sv -----
`timescale 1ns / 1ps

module top_k_score_selector_unit_tb;

    localparam int DEPTH      = tksel_pkg::LIST_DEPTH_DEF;
    localparam int CMD_W      = tksel_pkg::CMD_W;
    localparam int ITEM_W     = tksel_pkg::ITEM_W;
    localparam int SCORE_W    = tksel_pkg::SCORE_W;
    localparam int RANK_W     = tksel_pkg::RANK_W;
    localparam int MATCH_W    = tksel_pkg::MATCH_W;
    localparam int HIT_W      = tksel_pkg::HIT_W;
    // cycles with no transfer on either side before the run is abandoned
    localparam int STALL_LIMIT = 4000;

    // one expected result transfer
    typedef struct {
        logic [MATCH_W-1:0] slot_cnt;
        logic [HIT_W-1:0]   hits;
        logic [ITEM_W-1:0]  item;
        logic [SCORE_W-1:0] score;
    } t_slot_result;

    // scoreboard: shadow copy of the sorted list and hit counter, plus the
    // queue of results still owed by the block
    class t_top_k_scoreboard;
        logic [ITEM_W-1:0]         slot_item [DEPTH];
        logic signed [SCORE_W-1:0] slot_score [DEPTH];
        logic [HIT_W-1:0]          hit_count;
        t_slot_result              owed_q [$];
        int                        n_fail;
        int                        n_seen;

        function new();
            wipe();
            n_fail = 0;
            n_seen = 0;
        endfunction

        function void wipe();
            foreach (slot_item[i]) begin
                slot_item[i]  = '0;
                slot_score[i] = tksel_pkg::SCORE_FLOOR;
            end
            hit_count = '0;
        endfunction

        // predict the result of one accepted command
        function void note_command(tksel_pkg::t_cmd cmd, logic [ITEM_W-1:0] item,
                                   logic signed [SCORE_W-1:0] score, logic trained,
                                   logic [RANK_W-1:0] rank);
            t_slot_result res;
            int top, cnt, sum;
            res = '{default: '0};
            case (cmd)
                tksel_pkg::CMD_CLEAR: begin
                    wipe();
                end
                tksel_pkg::CMD_OFFER: begin
                    // highest slot whose score does not exceed the new one
                    top = -1;
                    for (int i = 0; i < DEPTH; i++) begin
                        if (slot_score[i] > score)
                            break;
                        top = i;
                    end
                    if (!trained && top >= 0) begin
                        for (int i = 0; i < top; i++) begin
                            slot_item[i]  = slot_item[i+1];
                            slot_score[i] = slot_score[i+1];
                        end
                        slot_item[top]  = item;
                        slot_score[top] = score;
                    end
                end
                tksel_pkg::CMD_QUERY: begin
                    cnt = 0;
                    foreach (slot_item[i])
                        if (slot_item[i] == item)
                            cnt++;
                    sum = int'(hit_count) + cnt;
                    hit_count = (sum > int'(tksel_pkg::HIT_MAX)) ? tksel_pkg::HIT_MAX
                                                                  : HIT_W'(sum);
                    res.slot_cnt = MATCH_W'(cnt);
                end
                default: begin
                    if (rank < DEPTH) begin
                        res.item  = slot_item[rank];
                        res.score = slot_score[rank];
                    end
                end
            endcase
            res.hits = hit_count;
            owed_q = {owed_q, res};
        endfunction

        task report(string what, logic [31:0] want, logic [31:0] got);
            $display("result %0d: %s mismatch, want %h got %h", n_seen, what, want, got);
            n_fail++;
        endtask

        task check_result(t_slot_result got);
            t_slot_result want;
            if (owed_q.size() == 0) begin
                report("unexpected result", '0, '0);
            end else begin
                want = owed_q.pop_front();
                if (got.slot_cnt !== want.slot_cnt)
                    report("slot_matches", 32'(want.slot_cnt), 32'(got.slot_cnt));
                if (got.hits !== want.hits)
                    report("hit_total", 32'(want.hits), 32'(got.hits));
                if (got.item !== want.item)
                    report("read_item", 32'(want.item), 32'(got.item));
                if (got.score !== want.score)
                    report("read_score", want.score, got.score);
            end
            n_seen++;
        endtask

        function int pending();
            return owed_q.size();
        endfunction
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_ready;
    logic [CMD_W-1:0]          i_command;
    logic [ITEM_W-1:0]         i_item_index;
    logic signed [SCORE_W-1:0] i_score;
    logic                      i_already_trained;
    logic [RANK_W-1:0]         i_rank;
    logic                      o_out_valid;
    logic                      i_out_ready;
    logic [MATCH_W-1:0]        o_slot_matches;
    logic [HIT_W-1:0]          o_hit_total;
    logic [ITEM_W-1:0]         o_read_item;
    logic signed [SCORE_W-1:0] o_read_score;

    top_k_score_selector_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_command        (i_command),
        .i_item_index     (i_item_index),
        .i_score          (i_score),
        .i_already_trained(i_already_trained),
        .i_rank           (i_rank),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_slot_matches   (o_slot_matches),
        .o_hit_total      (o_hit_total),
        .o_read_item      (o_read_item),
        .o_read_score     (o_read_score)
    );

    t_top_k_scoreboard sb;
    int src_idle_pct;
    int sink_idle_pct;
    int n_issued;
    int quiet_cycles;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // result side stalls at random, changed on the falling edge only
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // result transfer check
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result('{o_slot_matches, o_hit_total, o_read_item, o_read_score});
    end

    // watchdog on cycles with no transfer at all
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send(input tksel_pkg::t_cmd cmd, input logic [ITEM_W-1:0] item,
                        input logic signed [SCORE_W-1:0] score, input logic trained,
                        input logic [RANK_W-1:0] rank);
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_command         <= cmd;
        i_item_index      <= item;
        i_score           <= score;
        i_already_trained <= trained;
        i_rank            <= rank;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_command(cmd, item, score, trained, rank);
        n_issued++;
        @(negedge i_clk);
    endtask

    // score styles: narrow integer band (lots of ties), full range, extremes mixed in
    function automatic logic signed [SCORE_W-1:0] pick_score(int mode);
        int s;
        case (mode)
            0: begin
                s = int'($urandom_range(32)) - 16;
                return s * 65536;
            end
            1: return $urandom;
            default: begin
                case ($urandom_range(9))
                    0: return {1'b0, {(SCORE_W-1){1'b1}}};
                    1: return tksel_pkg::SCORE_FLOOR;
                    2: return '0;
                    3: return '1;
                    default: return $urandom;
                endcase
            end
        endcase
    endfunction

    // mostly clear + a burst of offers, queries and reads over a small item pool
    task automatic random_stream(input int target);
        logic [ITEM_W-1:0] pool [8];
        logic [ITEM_W-1:0] it;
        int mode, len, r;
        while (n_issued < target) begin
            foreach (pool[k])
                pool[k] = ITEM_W'($urandom);
            mode = $urandom_range(2);
            if ($urandom_range(3) != 0)
                send(tksel_pkg::CMD_CLEAR, ITEM_W'($urandom), $urandom, 1'($urandom),
                     RANK_W'($urandom));
            len = $urandom_range(40, 140);
            repeat (len) begin
                r  = $urandom_range(99);
                it = ($urandom_range(4) == 0) ? ITEM_W'($urandom) : pool[$urandom_range(7)];
                if (r < 55)
                    send(tksel_pkg::CMD_OFFER, it, pick_score(mode), $urandom_range(9) == 0,
                         RANK_W'($urandom));
                else if (r < 72)
                    send(tksel_pkg::CMD_QUERY, ($urandom_range(9) == 0) ? '0 : it, $urandom,
                         1'($urandom), RANK_W'($urandom));
                else if (r < 97)
                    send(tksel_pkg::CMD_READ, ITEM_W'($urandom), $urandom, 1'($urandom),
                         RANK_W'($urandom));
                else
                    send(tksel_pkg::CMD_CLEAR, it, $urandom, 1'($urandom), RANK_W'($urandom));
            end
        end
    endtask

    initial begin
        sb                = new();
        n_issued          = 0;
        src_idle_pct      = 37;
        sink_idle_pct     = 85;
        i_rst_n           = 1'b0;
        i_in_valid        = 1'b0;
        i_command         = tksel_pkg::CMD_CLEAR;
        i_item_index      = '0;
        i_score           = '0;
        i_already_trained = 1'b0;
        i_rank            = '0;
        i_out_ready       = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: reset contents, extremes, skip, ties, out-of-range reads
        send(tksel_pkg::CMD_READ, '0, '0, 1'b0, '0);
        send(tksel_pkg::CMD_QUERY, '0, '0, 1'b0, '0);
        send(tksel_pkg::CMD_OFFER, '1, {1'b0, {(SCORE_W-1){1'b1}}}, 1'b0, '0);
        send(tksel_pkg::CMD_OFFER, 20'h12345, tksel_pkg::SCORE_FLOOR, 1'b0, '0);
        send(tksel_pkg::CMD_OFFER, 20'hABCDE, '0, 1'b1, '0);
        send(tksel_pkg::CMD_OFFER, 20'h00001, 32'h0001_0000, 1'b0, '0);
        send(tksel_pkg::CMD_OFFER, 20'h00002, 32'h0001_0000, 1'b0, '0);
        send(tksel_pkg::CMD_OFFER, 20'h00003, 32'hFFFF_0000, 1'b0, '0);
        send(tksel_pkg::CMD_READ, '0, '0, 1'b0, 6'd49);
        send(tksel_pkg::CMD_READ, '0, '0, 1'b0, 6'd48);
        send(tksel_pkg::CMD_READ, '0, '0, 1'b0, 6'd47);
        send(tksel_pkg::CMD_READ, '0, '0, 1'b0, 6'd46);
        send(tksel_pkg::CMD_READ, '0, '0, 1'b0, 6'd45);
        send(tksel_pkg::CMD_READ, '0, '0, 1'b0, 6'd50);
        send(tksel_pkg::CMD_READ, '1, '1, 1'b1, '1);
        send(tksel_pkg::CMD_QUERY, '1, '0, 1'b0, '0);
        send(tksel_pkg::CMD_QUERY, 20'h12345, '0, 1'b0, '0);
        send(tksel_pkg::CMD_QUERY, 20'hABCDE, '0, 1'b0, '0);
        send(tksel_pkg::CMD_CLEAR, '1, '1, 1'b1, '1);
        send(tksel_pkg::CMD_READ, '0, '0, 1'b0, '0);
        send(tksel_pkg::CMD_QUERY, 20'h00001, '0, 1'b0, '0);

        random_stream(n_issued + 320);

        src_idle_pct  = 85;
        sink_idle_pct = 37;
        random_stream(n_issued + 320);

        // no idling: a run of queries on the fill item builds up the hit count
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        send(tksel_pkg::CMD_CLEAR, '0, '0, 1'b0, '0);
        repeat (60) begin
            if ($urandom_range(19) == 0)
                send(tksel_pkg::CMD_READ, ITEM_W'($urandom), $urandom, 1'($urandom),
                     RANK_W'($urandom));
            else
                send(tksel_pkg::CMD_QUERY, '0, $urandom, 1'($urandom), RANK_W'($urandom));
        end
        random_stream(n_issued + 220);

        i_in_valid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (sb.n_fail == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/tksel_pkg.sv
hdl/tksel_cell.sv
hdl/tksel_cnt.sv
hdl/top_k_score_selector_unit.sv
tb/sv/top_k_score_selector_unit_tb.sv
